[src/lgac_pkg.sv]
package lgac_pkg;

  // grid geometry
  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;
  localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW          = $clog2(CELLS);
  localparam int CW          = $clog2(GRID_WIDTH);
  localparam int RW          = $clog2(GRID_HEIGHT);

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // pixel: bit 3 mark, bits 2..0 color
  typedef logic [3:0] pixel_t;

  // 3x3 neighborhood, index 3*row + col from the top-left corner
  typedef pixel_t [8:0] window_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] col;
    logic [5:0] row;
    pixel_t     pixel_in;
  } item_t;

  typedef struct packed {
    pixel_t pixel_out;
    logic   op_done;
  } result_t;

endpackage

[src/life_grid_generation_with_age_colors_top.sv]
// channel   direction  handshake              word
// item      in         start high, busy low   lgac_pkg::item_t
// result    out        strobe for one cycle   lgac_pkg::result_t
//
// write and unknown commands are answered without raising busy.
// read goes through a memory read, then the registered result.
// a generation is one raster sweep of the single read port, with the rule unit
// fed from a line of two rows plus two pixels.
// after reset a clearing pass over every cell holds busy high.
// the receiver cannot stall: strobe marks each result for one cycle only.
module life_grid_generation_with_age_colors_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lgac_pkg::item_t    item,
  output logic               strobe,
  output lgac_pkg::result_t  result
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_STEP  = 2'd3;

  localparam int LINE_LEN = 2 * lgac_pkg::GRID_WIDTH + 2;
  localparam int W        = lgac_pkg::GRID_WIDTH;
  localparam logic [lgac_pkg::AW-1:0] LAST_ADDR  = lgac_pkg::AW'(lgac_pkg::CELLS - 1);
  localparam logic [lgac_pkg::AW-1:0] CENTER_OFS = lgac_pkg::AW'(lgac_pkg::GRID_WIDTH + 1);
  localparam logic [lgac_pkg::CW-1:0] LAST_COL   = lgac_pkg::CW'(lgac_pkg::GRID_WIDTH - 1);

  logic [1:0]                 state;
  logic [lgac_pkg::AW-1:0]    clr_idx;

  // memory
  lgac_pkg::pixel_t           mem [lgac_pkg::CELLS];
  lgac_pkg::pixel_t           rdata;
  logic [lgac_pkg::AW-1:0]    rd_addr;
  logic [lgac_pkg::AW-1:0]    wr_addr;
  lgac_pkg::pixel_t           wr_data;
  logic                       wr_en;

  // sweep read stage
  logic                       rlive;
  logic [lgac_pkg::AW-1:0]    ridx;
  logic [lgac_pkg::CW-1:0]    rcol;
  logic [lgac_pkg::RW-1:0]    rrow;

  // sweep data stage
  logic                       dvalid;
  logic [lgac_pkg::AW-1:0]    daddr;
  logic [lgac_pkg::CW-1:0]    dcol;
  logic [lgac_pkg::RW-1:0]    drow;
  lgac_pkg::pixel_t           line [LINE_LEN];
  lgac_pkg::window_t          win;
  lgac_pkg::pixel_t           cell_new;
  logic                       center_ok;

  // command decode
  logic                       accept;
  logic                       in_grid;
  logic                       rd_inside;
  logic [lgac_pkg::AW-1:0]    item_addr;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign in_grid = (int'(item.col) < lgac_pkg::GRID_WIDTH) &&
                   (int'(item.row) < lgac_pkg::GRID_HEIGHT);
  assign item_addr = lgac_pkg::AW'(int'(item.row) * lgac_pkg::GRID_WIDTH + int'(item.col));

  // 3x3 window: newest read word plus fixed taps of the line
  always_comb begin
    win[8] = rdata;
    win[7] = line[0];
    win[6] = line[1];
    win[5] = line[W - 1];
    win[4] = line[W];
    win[3] = line[W + 1];
    win[2] = line[2 * W - 1];
    win[1] = line[2 * W];
    win[0] = line[2 * W + 1];
  end

  lgac_cell u_cell (
    .win   (win),
    .pixel (cell_new)
  );

  // window is complete once the newest word is at row two and column two or beyond
  assign center_ok = dvalid && (drow >= lgac_pkg::RW'(2)) && (dcol >= lgac_pkg::CW'(2));

  // memory port selection
  always_comb begin
    rd_addr = (state == ST_STEP) ? ridx : item_addr;
    wr_en   = 1'b0;
    wr_addr = item_addr;
    wr_data = item.pixel_in;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = '0;
      end
      ST_IDLE: begin
        wr_en = accept && (item.cmd == lgac_pkg::CMD_WRITE) && in_grid;
      end
      ST_STEP: begin
        wr_en   = center_ok;
        wr_addr = daddr - CENTER_OFS;
        wr_data = cell_new;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // grid memory, registered read
  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // pixel line for the window
  always_ff @(posedge clk) begin
    if (dvalid) begin
      line[0] <= rdata;
      for (int i = 1; i < LINE_LEN; i++) begin
        line[i] <= line[i - 1];
      end
    end
  end

  // sweep data stage payload
  always_ff @(posedge clk) begin
    daddr <= ridx;
    dcol  <= rcol;
    drow  <= rrow;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      rlive     <= 1'b0;
      dvalid    <= 1'b0;
      strobe    <= 1'b0;
      ridx      <= '0;
      rcol      <= '0;
      rrow      <= '0;
      rd_inside <= 1'b0;
    end else begin
      strobe <= 1'b0;
      dvalid <= (state == ST_STEP) && rlive;
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (item.cmd)
              lgac_pkg::CMD_WRITE: begin
                strobe <= 1'b1;
                result <= '{pixel_out: '0, op_done: 1'b1};
              end
              lgac_pkg::CMD_READ: begin
                rd_inside <= in_grid;
                state     <= ST_READ;
              end
              lgac_pkg::CMD_STEP: begin
                ridx  <= '0;
                rcol  <= '0;
                rrow  <= '0;
                rlive <= 1'b1;
                state <= ST_STEP;
              end
              default: begin
                strobe <= 1'b1;
                result <= '{pixel_out: '0, op_done: 1'b0};
              end
            endcase
          end
        end
        ST_READ: begin
          strobe <= 1'b1;
          result <= '{pixel_out: (rd_inside ? rdata : '0), op_done: 1'b1};
          state  <= ST_IDLE;
        end
        ST_STEP: begin
          // raster read walk
          if (rlive) begin
            if (ridx == LAST_ADDR) begin
              rlive <= 1'b0;
            end else begin
              ridx <= ridx + 1'b1;
            end
            if (rcol == LAST_COL) begin
              rcol <= '0;
              rrow <= rrow + 1'b1;
            end else begin
              rcol <= rcol + 1'b1;
            end
          end
          // last word seen, every interior cell written
          if (dvalid && (daddr == LAST_ADDR)) begin
            strobe <= 1'b1;
            result <= '{pixel_out: '0, op_done: 1'b1};
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a read is answered in the cycle after the read state
  a_read_answer: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (strobe && result.op_done))
    else $error("read result missing");

  // an accepted read or step holds the block busy in the next cycle
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.cmd == lgac_pkg::CMD_READ || item.cmd == lgac_pkg::CMD_STEP)) |=> busy)
    else $error("busy not raised");

  // the sweep data stage only runs during a generation
  a_sweep_only: assert property (@(posedge clk) disable iff (rst)
    dvalid |-> (state == ST_STEP))
    else $error("sweep data outside a generation");

  // an unknown command never returns pixel data
  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.op_done) |-> (result.pixel_out == '0))
    else $error("pixel data on a failed command");

endmodule

[src/lgac_cell.sv]
module lgac_cell (
  input  lgac_pkg::window_t win,
  output lgac_pkg::pixel_t  pixel
);

  localparam lgac_pkg::pixel_t WHITE = 4'b0111;
  localparam lgac_pkg::pixel_t CYAN  = 4'b0110;
  localparam lgac_pkg::pixel_t BLUE  = 4'b0100;

  logic [8:0]       alive;
  logic [3:0]       count;
  logic             mark;
  lgac_pkg::pixel_t center;

  // live flags of the whole window
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      alive[i] = |win[i][2:0];
    end
  end

  // neighbor count, center excluded
  always_comb begin
    count = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        count = count + {3'b000, alive[i]};
      end
    end
  end

  // survive on two or three, birth on three, a dead cell keeps its old mark
  assign center = win[4];
  always_comb begin
    if (alive[4]) begin
      mark = (count == 4'd2) || (count == 4'd3);
    end else if (count == 4'd3) begin
      mark = 1'b1;
    end else begin
      mark = center[3];
    end
  end

  // age colors: black to white to cyan to blue, unmarked cells go black
  always_comb begin
    if (!mark) begin
      pixel = 4'b0000;
    end else begin
      case (center[2:0])
        3'd0:    pixel = WHITE;
        3'd7:    pixel = CYAN;
        3'd6:    pixel = BLUE;
        3'd4:    pixel = BLUE;
        default: pixel = {1'b1, center[2:0]};
      endcase
    end
  end

endmodule
